// ===== hdl/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types, codes and arithmetic helpers for the biased matrix
// factorization SGD step unit.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int unsigned NUM_USERS_DEF  = 1024;
  localparam int unsigned NUM_ITEMS_DEF  = 1024;
  localparam int unsigned FACTOR_DIM_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // rates and weights are Q0.16
  localparam int unsigned COEF_BITS = 16;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [3:0] {
    OP_TRAIN = 4'd0,
    OP_WR_UF = 4'd1,
    OP_WR_IF = 4'd2,
    OP_WR_UB = 4'd3,
    OP_WR_IB = 4'd4,
    OP_RD_UF = 4'd5,
    OP_RD_IF = 4'd6,
    OP_RD_UB = 4'd7,
    OP_RD_IB = 4'd8
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LR   = 3'd0,
    CFG_LUF  = 3'd1,
    CFG_LIF  = 3'd2,
    CFG_LUB  = 3'd3,
    CFG_LIB  = 3'd4,
    CFG_AVG  = 3'd5,
    CFG_MODE = 3'd6
  } cfg_e;

  typedef enum logic [3:0] {
    ST_NONE     = 4'd0,
    ST_LOAD     = 4'd1,
    ST_PRED     = 4'd2,
    ST_SIG_A    = 4'd3,
    ST_SIG_B    = 4'd4,
    ST_ERR      = 4'd5,
    ST_GE       = 4'd6,
    ST_BIAS_MUL = 4'd7,
    ST_BIAS_WR  = 4'd8,
    ST_SWRITE   = 4'd9,
    ST_SREAD    = 4'd10,
    ST_SREAD_CAP = 4'd11,
    ST_OUT      = 4'd12
  } step_e;

  typedef struct packed {
    step_e step;
    logic  stream;  // issue one factor element read this cycle
    logic  upd;     // streaming pass is the update pass
  } cmd_t;

  typedef struct packed {
    logic busy;     // element pipeline still holds work
  } sts_t;

  typedef struct packed {
    logic [15:0]        lr;
    logic [15:0]        luf;
    logic [15:0]        lif;
    logic signed [16:0] lub;
    logic signed [16:0] lib;
    logic signed [31:0] avg;
    logic [1:0]         mode;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // 1 - lr*lambda in unsigned Q1.16
  function automatic logic [16:0] decay(input logic [15:0] lr, input logic [15:0] lam);
    logic [31:0] p;
    p = lr * lam;
    return 17'h10000 - {1'b0, p[31:16]};
  endfunction

  // index wrap by conditional subtraction, ids are at most 10 bits
  function automatic logic [31:0] wrap_idx(input logic [31:0] v, input logic [31:0] n);
    logic [31:0] r;
    r = v;
    for (int k = 9; k >= 0; k--) begin
      if (r >= (n << k)) begin
        r = r - (n << k);
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/mfs_if.sv =====
// ----------------------------------------------------------------------------
// mfs_in_if / mfs_out_if
// Valid/ready request and result channels of the SGD step unit.
// ----------------------------------------------------------------------------
interface mfs_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         op;
  logic [9:0]         user_id;
  logic [9:0]         item_id;
  logic [4:0]         dim_index;
  logic signed [31:0] rating;
  logic signed [31:0] write_value;

  modport source (output valid, op, user_id, item_id, dim_index, rating, write_value,
                  input ready);
  modport sink   (input valid, op, user_id, item_id, dim_index, rating, write_value,
                  output ready);
endinterface

interface mfs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] prediction;
  logic signed [31:0] scaled_error;
  logic signed [31:0] read_value;

  modport source (output valid, prediction, scaled_error, read_value, input ready);
  modport sink   (input valid, prediction, scaled_error, read_value, output ready);
endinterface

// ===== hdl/mfs_ram.sv =====
// ----------------------------------------------------------------------------
// mfs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mfs_datapath.sv =====
// ----------------------------------------------------------------------------
// mfs_datapath
// Factor and bias memories, element pipeline and the prediction/error math.
// ----------------------------------------------------------------------------
module mfs_datapath #(
  parameter int unsigned NUM_USERS  = mfs_pkg::NUM_USERS_DEF,
  parameter int unsigned NUM_ITEMS  = mfs_pkg::NUM_ITEMS_DEF,
  parameter int unsigned FACTOR_DIM = mfs_pkg::FACTOR_DIM_DEF,
  parameter int unsigned FRAC_BITS  = mfs_pkg::FRAC_BITS_DEF,
  parameter int unsigned DW = (FACTOR_DIM > 1) ? $clog2(FACTOR_DIM) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mfs_pkg::cmd_t      cmd_i,
  input  logic [DW-1:0]      dim_i,
  output mfs_pkg::sts_t      sts_o,
  input  mfs_pkg::cfg_t      cfg_i,
  input  logic [3:0]         op_i,
  input  logic [9:0]         user_id_i,
  input  logic [9:0]         item_id_i,
  input  logic [4:0]         dim_index_i,
  input  logic signed [31:0] rating_i,
  input  logic signed [31:0] write_value_i,
  output logic signed [31:0] prediction_o,
  output logic signed [31:0] scaled_error_o,
  output logic signed [31:0] read_value_o
);

  import mfs_pkg::*;

  localparam int unsigned UW   = $clog2(NUM_USERS);
  localparam int unsigned IW   = $clog2(NUM_ITEMS);
  localparam int unsigned UFAW = $clog2(NUM_USERS * FACTOR_DIM);
  localparam int unsigned IFAW = $clog2(NUM_ITEMS * FACTOR_DIM);
  localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // captured request
  logic [3:0]         op_q;
  logic [UW-1:0]      urow_q;
  logic [IW-1:0]      irow_q;
  logic [DW-1:0]      dix_q;
  logic signed [31:0] rating_q;
  logic signed [31:0] wval_q;

  // decay factors
  logic [16:0] glu_q, gli_q, gub_q, gib_q;

  // element pipeline
  logic          v1_q, v2_q, up1_q, up2_q;
  logic [DW-1:0] d1_q, d2_q;
  logic signed [63:0] pui_q, pgi_q, pgu_q, plu_q, pli_q;

  // per-request math
  logic signed [63:0] acc_q, err_q, bup_q, bip_q;
  logic signed [31:0] pred_q, p_q, sl_q, ge_q, rd_q;
  logic signed [31:0] out_pred_q, out_ge_q, out_rd_q;

  logic signed [31:0] uf_rd, if_rd, ub_rd, ib_rd;
  logic [31:0]        uf_rdata, if_rdata, ub_rdata, ib_rdata;
  logic signed [31:0] uf_new, if_new, ub_new, ib_new;
  logic signed [63:0] pred_sum, sig_x;
  logic ub_on, ib_on;

  logic            uf_we, if_we, ub_we, ib_we, f_re, b_re;
  logic [DW-1:0]   rd_dim, wr_dim;
  logic [UFAW-1:0] uf_raddr, uf_waddr;
  logic [IFAW-1:0] if_raddr, if_waddr;
  logic [31:0]     uf_wdata, if_wdata, ub_wdata, ib_wdata;

  assign ub_on = ~cfg_i.lub[16];
  assign ib_on = ~cfg_i.lib[16];

  assign uf_rd = $signed(uf_rdata);
  assign if_rd = $signed(if_rdata);
  assign ub_rd = $signed(ub_rdata);
  assign ib_rd = $signed(ib_rdata);

  assign sts_o.busy = v1_q | v2_q;

  always_ff @(posedge clk_i) begin
    glu_q <= decay(cfg_i.lr, cfg_i.luf);
    gli_q <= decay(cfg_i.lr, cfg_i.lif);
    gub_q <= decay(cfg_i.lr, cfg_i.lub[15:0]);
    gib_q <= decay(cfg_i.lr, cfg_i.lib[15:0]);
  end

  // ---------------- addressing ----------------
  assign rd_dim = cmd_i.stream ? dim_i : dix_q;
  assign wr_dim = v2_q ? d2_q : dix_q;
  assign uf_raddr = UFAW'(32'(urow_q) * 32'(FACTOR_DIM) + 32'(rd_dim));
  assign if_raddr = IFAW'(32'(irow_q) * 32'(FACTOR_DIM) + 32'(rd_dim));
  assign uf_waddr = UFAW'(32'(urow_q) * 32'(FACTOR_DIM) + 32'(wr_dim));
  assign if_waddr = IFAW'(32'(irow_q) * 32'(FACTOR_DIM) + 32'(wr_dim));

  assign f_re = cmd_i.stream || (cmd_i.step == ST_SREAD);
  assign b_re = (cmd_i.stream && !cmd_i.upd) || (cmd_i.step == ST_SREAD);

  // new factor words from the registered products
  assign uf_new = sat32((pgi_q >>> FRAC_BITS) + (plu_q >>> COEF_BITS));
  assign if_new = sat32((pgu_q >>> FRAC_BITS) + (pli_q >>> COEF_BITS));
  assign ub_new = sat32((bup_q >>> COEF_BITS) + 64'(ge_q));
  assign ib_new = sat32((bip_q >>> COEF_BITS) + 64'(ge_q));

  assign uf_we = (v2_q && up2_q) || (cmd_i.step == ST_SWRITE && op_q == OP_WR_UF);
  assign if_we = (v2_q && up2_q) || (cmd_i.step == ST_SWRITE && op_q == OP_WR_IF);
  assign ub_we = (cmd_i.step == ST_BIAS_WR && ub_on) ||
                 (cmd_i.step == ST_SWRITE && op_q == OP_WR_UB);
  assign ib_we = (cmd_i.step == ST_BIAS_WR && ib_on) ||
                 (cmd_i.step == ST_SWRITE && op_q == OP_WR_IB);

  assign uf_wdata = v2_q ? uf_new : wval_q;
  assign if_wdata = v2_q ? if_new : wval_q;
  assign ub_wdata = (cmd_i.step == ST_BIAS_WR) ? ub_new : wval_q;
  assign ib_wdata = (cmd_i.step == ST_BIAS_WR) ? ib_new : wval_q;

  mfs_ram #(.WIDTH(32), .DEPTH(NUM_USERS * FACTOR_DIM)) u_uf_ram (
    .clk_i, .we_i(uf_we), .waddr_i(uf_waddr), .wdata_i(uf_wdata),
    .re_i(f_re), .raddr_i(uf_raddr), .rdata_o(uf_rdata)
  );
  mfs_ram #(.WIDTH(32), .DEPTH(NUM_ITEMS * FACTOR_DIM)) u_if_ram (
    .clk_i, .we_i(if_we), .waddr_i(if_waddr), .wdata_i(if_wdata),
    .re_i(f_re), .raddr_i(if_raddr), .rdata_o(if_rdata)
  );
  mfs_ram #(.WIDTH(32), .DEPTH(NUM_USERS)) u_ub_ram (
    .clk_i, .we_i(ub_we), .waddr_i(urow_q), .wdata_i(ub_wdata),
    .re_i(b_re), .raddr_i(urow_q), .rdata_o(ub_rdata)
  );
  mfs_ram #(.WIDTH(32), .DEPTH(NUM_ITEMS)) u_ib_ram (
    .clk_i, .we_i(ib_we), .waddr_i(irow_q), .wdata_i(ib_wdata),
    .re_i(b_re), .raddr_i(irow_q), .rdata_o(ib_rdata)
  );

  // ---------------- element pipeline ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.stream;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    up1_q <= cmd_i.upd;
    up2_q <= up1_q;
    d1_q  <= dim_i;
    d2_q  <= d1_q;
    if (v1_q) begin
      pui_q <= uf_rd * if_rd;
      pgi_q <= ge_q * if_rd;
      pgu_q <= ge_q * uf_rd;
      plu_q <= $signed({1'b0, glu_q}) * uf_rd;
      pli_q <= $signed({1'b0, gli_q}) * if_rd;
    end
  end

  // ---------------- prediction and error ----------------
  assign pred_sum = 64'(sat32(acc_q))
                  + (cfg_i.mode[0] ? 64'(cfg_i.avg) : 64'sd0)
                  + (ub_on ? 64'(ub_rd) : 64'sd0)
                  + (ib_on ? 64'(ib_rd) : 64'sd0);

  // hard sigmoid
  assign sig_x = HALF + (64'(pred_q) >>> 2);

  always_ff @(posedge clk_i) begin
    if (v2_q && !up2_q) begin
      acc_q <= acc_q + (pui_q >>> FRAC_BITS);
    end
    case (cmd_i.step)
      ST_LOAD: begin
        op_q     <= op_i;
        urow_q   <= UW'(wrap_idx(32'(user_id_i), 32'(NUM_USERS)));
        irow_q   <= IW'(wrap_idx(32'(item_id_i), 32'(NUM_ITEMS)));
        dix_q    <= DW'(wrap_idx(32'(dim_index_i), 32'(FACTOR_DIM)));
        rating_q <= rating_i;
        wval_q   <= write_value_i;
        acc_q    <= 64'sd0;
        pred_q   <= 32'sd0;
        ge_q     <= 32'sd0;
        rd_q     <= 32'sd0;
      end
      ST_PRED: pred_q <= sat32(pred_sum);
      ST_SIG_A: begin
        if (cfg_i.mode[1]) begin
          if (sig_x < 64'sd0) begin
            p_q <= 32'sd0;
          end else if (sig_x > ONE) begin
            p_q <= 32'(ONE);
          end else begin
            p_q <= 32'(sig_x);
          end
        end
      end
      ST_SIG_B: begin
        if (cfg_i.mode[1]) begin
          pred_q <= p_q;
          sl_q   <= 32'((64'(p_q) * (ONE - 64'(p_q))) >>> FRAC_BITS);
        end
      end
      ST_ERR: begin
        if (cfg_i.mode[1]) begin
          err_q <= ((64'(rating_q) - 64'(p_q)) * 64'(sl_q)) >>> FRAC_BITS;
        end else begin
          err_q <= 64'(rating_q) - 64'(pred_q);
        end
      end
      ST_GE: ge_q <= sat32((err_q * $signed({48'd0, cfg_i.lr})) >>> COEF_BITS);
      ST_BIAS_MUL: begin
        bup_q <= $signed({1'b0, gub_q}) * ub_rd;
        bip_q <= $signed({1'b0, gib_q}) * ib_rd;
      end
      ST_SREAD_CAP: begin
        case (op_q)
          OP_RD_UF: rd_q <= uf_rd;
          OP_RD_IF: rd_q <= if_rd;
          OP_RD_UB: rd_q <= ub_rd;
          OP_RD_IB: rd_q <= ib_rd;
          default:  rd_q <= 32'sd0;
        endcase
      end
      ST_OUT: begin
        out_pred_q <= pred_q;
        out_ge_q   <= ge_q;
        out_rd_q   <= rd_q;
      end
      default: ;
    endcase
  end

  assign prediction_o   = out_pred_q;
  assign scaled_error_o = out_ge_q;
  assign read_value_o   = out_rd_q;

endmodule

// ===== hdl/mfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfs_ctrl
// SGD step sequencer: dot pass, error steps, update pass, bias update, result; table writes, reads.
// ----------------------------------------------------------------------------
module mfs_ctrl #(
  parameter int unsigned FACTOR_DIM = mfs_pkg::FACTOR_DIM_DEF,
  parameter int unsigned DW = (FACTOR_DIM > 1) ? $clog2(FACTOR_DIM) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [3:0]    in_op_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mfs_pkg::cmd_t cmd_o,
  output logic [DW-1:0] dim_o,
  input  mfs_pkg::sts_t sts_i
);

  import mfs_pkg::*;

  localparam logic [DW-1:0] LAST = DW'(FACTOR_DIM - 1);

  typedef enum logic [15:0] {
    S_IDLE       = 16'h0001,
    S_DOT        = 16'h0002,
    S_DOT_DRAIN  = 16'h0004,
    S_PRED       = 16'h0008,
    S_SIG_A      = 16'h0010,
    S_SIG_B      = 16'h0020,
    S_ERR        = 16'h0040,
    S_GE         = 16'h0080,
    S_UPD        = 16'h0100,
    S_UPD_DRAIN  = 16'h0200,
    S_BIAS_MUL   = 16'h0400,
    S_BIAS_WR    = 16'h0800,
    S_SWRITE     = 16'h1000,
    S_SREAD      = 16'h2000,
    S_SREAD_WAIT = 16'h4000,
    S_DONE       = 16'h8000
  } state_e;

  state_e        state_q, state_d;
  logic [DW-1:0] dim_q, dim_d;
  logic          out_valid_q, out_valid_d;
  logic          accept, load_out;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load_out    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign dim_o       = dim_q;

  always_comb begin
    state_d     = state_q;
    dim_d       = dim_q;
    cmd_o       = '{step: ST_NONE, stream: 1'b0, upd: 1'b0};
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.step = ST_LOAD;
          dim_d      = '0;
          case (in_op_i) inside
            OP_TRAIN:                             state_d = S_DOT;
            OP_WR_UF, OP_WR_IF, OP_WR_UB, OP_WR_IB: state_d = S_SWRITE;
            OP_RD_UF, OP_RD_IF, OP_RD_UB, OP_RD_IB: state_d = S_SREAD;
            default:                              state_d = S_DONE;
          endcase
        end
      end
      S_DOT, S_UPD: begin
        cmd_o.stream = 1'b1;
        cmd_o.upd    = (state_q == S_UPD);
        if (dim_q == LAST) begin
          dim_d   = '0;
          state_d = (state_q == S_DOT) ? S_DOT_DRAIN : S_UPD_DRAIN;
        end else begin
          dim_d = dim_q + 1'b1;
        end
      end
      S_DOT_DRAIN: if (!sts_i.busy) state_d = S_PRED;
      S_PRED: begin
        cmd_o.step = ST_PRED;
        state_d    = S_SIG_A;
      end
      S_SIG_A: begin
        cmd_o.step = ST_SIG_A;
        state_d    = S_SIG_B;
      end
      S_SIG_B: begin
        cmd_o.step = ST_SIG_B;
        state_d    = S_ERR;
      end
      S_ERR: begin
        cmd_o.step = ST_ERR;
        state_d    = S_GE;
      end
      S_GE: begin
        cmd_o.step = ST_GE;
        state_d    = S_UPD;
      end
      S_UPD_DRAIN: if (!sts_i.busy) state_d = S_BIAS_MUL;
      S_BIAS_MUL: begin
        cmd_o.step = ST_BIAS_MUL;
        state_d    = S_BIAS_WR;
      end
      S_BIAS_WR: begin
        cmd_o.step = ST_BIAS_WR;
        state_d    = S_DONE;
      end
      S_SWRITE: begin
        cmd_o.step = ST_SWRITE;
        state_d    = S_DONE;
      end
      S_SREAD: begin
        cmd_o.step = ST_SREAD;
        state_d    = S_SREAD_WAIT;
      end
      S_SREAD_WAIT: begin
        cmd_o.step = ST_SREAD_CAP;
        state_d    = S_DONE;
      end
      S_DONE: begin
        // output register frees up when the waiting result is taken
        if (load_out) begin
          cmd_o.step  = ST_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dim_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dim_q       <= dim_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q)
    else $error("result load did not raise valid");

  a_pipe_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRED || state_q == S_BIAS_MUL) |-> !sts_i.busy)
    else $error("element pipeline busy after drain");

  a_update_follows_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && dim_q == '0) |-> ($past(state_q) == S_GE))
    else $error("update pass started without a fresh error term");
`endif

endmodule

// ===== hdl/matrix_factorization_sgd_step_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_factorization_sgd_step_unit
// Biased matrix factorization SGD step over on-chip factor and bias tables.
// ----------------------------------------------------------------------------
// One request at a time. A train request streams the dot product, works out
// the error and scaled error, streams the update pass, then updates the
// biases, and the unit is ready again as the result becomes valid. The factor
// memories have one read port each, so the dot product streams one element per
// cycle, then the update pass streams the same elements again and writes them
// back through the write port. Each pass ends with a drain of the element
// pipeline. The prediction, the two sigmoid steps, the error, the scaled error,
// the bias multiply, the bias write and the output register load are each a
// state of their own. Table writes pass through a write state and table reads
// through a read and a capture state. The tables come up undefined and must
// be loaded with write requests before they are read or trained on; there is
// no clearing pass. A finished result waits in the output register while the
// next request is accepted.
module matrix_factorization_sgd_step_unit #(
  parameter int unsigned NUM_USERS  = mfs_pkg::NUM_USERS_DEF,
  parameter int unsigned NUM_ITEMS  = mfs_pkg::NUM_ITEMS_DEF,
  parameter int unsigned FACTOR_DIM = mfs_pkg::FACTOR_DIM_DEF,
  parameter int unsigned FRAC_BITS  = mfs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mfs_in_if.sink                         in_ch,
  mfs_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  logic [mfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                    cfg_data_i
);

  import mfs_pkg::*;

  localparam int unsigned DW = (FACTOR_DIM > 1) ? $clog2(FACTOR_DIM) : 1;

  cfg_t          cfg_q;
  cmd_t          cmd;
  sts_t          sts;
  logic [DW-1:0] dim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lr   <= 16'd655;
      cfg_q.luf  <= 16'd655;
      cfg_q.lif  <= 16'd655;
      cfg_q.lub  <= 17'sd655;
      cfg_q.lib  <= 17'sd655;
      cfg_q.avg  <= 32'sd0;
      cfg_q.mode <= 2'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LR:   cfg_q.lr   <= cfg_data_i[15:0];
        CFG_LUF:  cfg_q.luf  <= cfg_data_i[15:0];
        CFG_LIF:  cfg_q.lif  <= cfg_data_i[15:0];
        CFG_LUB:  cfg_q.lub  <= $signed(cfg_data_i[16:0]);
        CFG_LIB:  cfg_q.lib  <= $signed(cfg_data_i[16:0]);
        CFG_AVG:  cfg_q.avg  <= $signed(cfg_data_i);
        CFG_MODE: cfg_q.mode <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  mfs_ctrl #(.FACTOR_DIM(FACTOR_DIM)) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .in_op_i     (in_ch.op),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .dim_o       (dim),
    .sts_i       (sts)
  );

  mfs_datapath #(
    .NUM_USERS (NUM_USERS),
    .NUM_ITEMS (NUM_ITEMS),
    .FACTOR_DIM(FACTOR_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i          (cmd),
    .dim_i          (dim),
    .sts_o          (sts),
    .cfg_i          (cfg_q),
    .op_i           (in_ch.op),
    .user_id_i      (in_ch.user_id),
    .item_id_i      (in_ch.item_id),
    .dim_index_i    (in_ch.dim_index),
    .rating_i       (in_ch.rating),
    .write_value_i  (in_ch.write_value),
    .prediction_o   (out_ch.prediction),
    .scaled_error_o (out_ch.scaled_error),
    .read_value_o   (out_ch.read_value)
  );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the matrix factorization SGD step unit: loads the
// factor and bias tables, then trains, writes and reads them under random flow
// control, comparing every response with an in-bench fixed point predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import mfs_pkg::*;

  localparam int NU  = 1024;
  localparam int NI  = 1024;
  localparam int DIM = 32;
  localparam int FB  = 16;
  // rows used by the training part, kept small so rows get hit often
  localparam int ROWS = 4;

  typedef struct packed {
    logic [3:0]         op;
    logic [9:0]         uid;
    logic [9:0]         iid;
    logic [4:0]         dix;
    logic signed [31:0] rating;
    logic signed [31:0] wval;
  } req_t;

  typedef struct packed {
    logic signed [31:0] pred;
    logic signed [31:0] ge;
    logic signed [31:0] rd;
  } rsp_t;

  typedef struct {
    req_t req;
    logic chk;   // typed-in expectation present
    rsp_t rsp;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  mfs_in_if  in_ch ();
  mfs_out_if out_ch ();

  matrix_factorization_sgd_step_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic [15:0]        p_lr, p_luf, p_lif;
  logic signed [16:0] p_lub, p_lib;
  logic signed [31:0] p_avg;
  logic [1:0]         p_mode;
  logic signed [31:0] uf_tab [NU*DIM];
  logic signed [31:0] if_tab [NI*DIM];
  logic signed [31:0] ub_tab [NU];
  logic signed [31:0] ib_tab [NI];

  rsp_t pending_rsp [$];
  int   n_sent, n_got, n_err, n_train, n_read;
  logic hold_rx;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic signed [63:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] decay_of(input logic [15:0] lam);
    logic [31:0] p;
    p = p_lr * lam;
    return 64'sd65536 - $signed({32'd0, p[31:16]});
  endfunction

  // one request: train returns prediction and scaled error, updates tables; also writes and reads
  function automatic rsp_t sgd_step(input req_t r);
    rsp_t o;
    int ub, ib;
    logic signed [63:0] acc, err, p, sl, ge, glp, glq, u0, i0;
    o = '0;
    ub = r.uid * DIM;
    ib = r.iid * DIM;
    case (r.op)
      OP_TRAIN: begin
        acc = 0;
        for (int d = 0; d < DIM; d++)
          acc += (64'(uf_tab[ub+d]) * 64'(if_tab[ib+d])) >>> FB;
        acc = sat(acc);
        if (p_mode[0]) acc += p_avg;
        if (p_lub >= 0) acc += ub_tab[r.uid];
        if (p_lib >= 0) acc += ib_tab[r.iid];
        acc = sat(acc);
        if (p_mode[1]) begin
          p = 64'sd32768 + (acc >>> 2);
          if (p < 0) p = 0;
          if (p > 64'sd65536) p = 64'sd65536;
          acc = p;
          sl = (p * (64'sd65536 - p)) >>> FB;
          err = ((64'(r.rating) - p) * sl) >>> FB;
        end else begin
          err = 64'(r.rating) - acc;
        end
        ge = sat((err * $signed({48'd0, p_lr})) >>> 16);
        glp = decay_of(p_luf);
        glq = decay_of(p_lif);
        for (int d = 0; d < DIM; d++) begin
          u0 = uf_tab[ub+d];
          i0 = if_tab[ib+d];
          uf_tab[ub+d] = 32'(sat(((ge * i0) >>> FB) + ((glp * u0) >>> 16)));
          if_tab[ib+d] = 32'(sat(((ge * u0) >>> FB) + ((glq * i0) >>> 16)));
        end
        if (p_lub >= 0)
          ub_tab[r.uid] = 32'(sat(((decay_of(p_lub[15:0]) * 64'(ub_tab[r.uid])) >>> 16)
                                  + ge));
        if (p_lib >= 0)
          ib_tab[r.iid] = 32'(sat(((decay_of(p_lib[15:0]) * 64'(ib_tab[r.iid])) >>> 16)
                                  + ge));
        o.pred = acc[31:0];
        o.ge = ge[31:0];
      end
      OP_WR_UF: uf_tab[ub+r.dix] = r.wval;
      OP_WR_IF: if_tab[ib+r.dix] = r.wval;
      OP_WR_UB: ub_tab[r.uid] = r.wval;
      OP_WR_IB: ib_tab[r.iid] = r.wval;
      OP_RD_UF: o.rd = uf_tab[ub+r.dix];
      OP_RD_IF: o.rd = if_tab[ib+r.dix];
      OP_RD_UB: o.rd = ub_tab[r.uid];
      OP_RD_IB: o.rd = ib_tab[r.iid];
      default: ;
    endcase
    return o;
  endfunction

  task automatic set_reg(input cfg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      CFG_LR:  p_lr = val[15:0];
      CFG_LUF: p_luf = val[15:0];
      CFG_LIF: p_lif = val[15:0];
      CFG_LUB: p_lub = val[16:0];
      CFG_LIB: p_lib = val[16:0];
      CFG_AVG: p_avg = val;
      default: p_mode = val[1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_rsp.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (100) @(negedge clk_i);
  endtask

  // offers one request, on the falling edge, until accepted
  task automatic send_req(input req_t r, input logic chk, input rsp_t typed);
    rsp_t e;
    in_ch.valid = 1'b1;
    {in_ch.op, in_ch.user_id, in_ch.item_id, in_ch.dim_index,
     in_ch.rating, in_ch.write_value} = r;
    do @(posedge clk_i); while (!in_ch.ready);
    e = sgd_step(r);
    if (chk && e !== typed) begin
      n_err++;
      if (n_err <= 10)
        $display("table row mismatch op %0d: typed %h model %h", r.op, typed, e);
    end
    pending_rsp = {pending_rsp, e};
    n_sent++;
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic gap();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  function automatic req_t rand_req();
    req_t r;
    int k;
    r.uid = 10'($urandom_range(0, ROWS - 1)) | ($urandom_range(0, 1) ? 10'h3f8 : 10'h0);
    r.iid = 10'($urandom_range(0, ROWS - 1)) | ($urandom_range(0, 1) ? 10'h3f8 : 10'h0);
    r.dix = 5'($urandom);
    r.rating = $urandom_range(0, 7) == 0 ? $urandom : $signed($urandom_range(0, 393216));
    r.wval = $urandom_range(0, 5) == 0 ? $urandom : $signed($urandom_range(0, 65536)) - 32768;
    k = $urandom_range(0, 99);
    if (k < 55) r.op = OP_TRAIN;
    else if (k < 75) r.op = 4'($urandom_range(OP_WR_UF, OP_WR_IB));
    else if (k < 95) r.op = 4'($urandom_range(OP_RD_UF, OP_RD_IB));
    else r.op = 4'($urandom_range(9, 15));
    return r;
  endfunction

  // receiver: random stall pattern, plus a long hold when hold_rx is set
  initial begin
    rsp_t got, e;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = !hold_rx && ($urandom_range(0, 9) > 2 || n_sent[6]);
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.prediction, out_ch.scaled_error, out_ch.read_value};
        n_got++;
        if (pending_rsp.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected response %h", got);
        end else begin
          e = pending_rsp.pop_front();
          if (got !== e) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: pred %h/%h ge %h/%h read %h/%h (exp/act)",
                       e.pred, got.pred, e.ge, got.ge, e.rd, got.rd);
          end
        end
      end
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    req_t r;
    int burst;
    logic [31:0] regs [7];
    bit held, paused;
    hold_rx = 1'b0;
    held = 1'b0; paused = 1'b0;
    n_sent = 0; n_got = 0; n_err = 0; n_train = 0; n_read = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_ch.valid = 1'b0;
    {in_ch.op, in_ch.user_id, in_ch.item_id, in_ch.dim_index,
     in_ch.rating, in_ch.write_value} = '0;
    p_lr = 655; p_luf = 655; p_lif = 655; p_lub = 655; p_lib = 655;
    p_avg = 0; p_mode = 0;
    for (int k = 0; k < NU*DIM; k++) begin uf_tab[k] = 0; if_tab[k] = 0; end
    for (int k = 0; k < NU; k++) begin ub_tab[k] = 0; ib_tab[k] = 0; end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // load every row the trains and random requests touch: low rows and their aliases near the top
    for (int k = 0; k < 2*ROWS; k++) begin
      r = '0;
      r.uid = k < ROWS ? 10'(k) : 10'(k - ROWS) | 10'h3f8;
      r.iid = r.uid;
      for (int d = 0; d < DIM; d++) begin
        r.dix = 5'(d);
        r.wval = $signed($urandom_range(0, 32768)) - 16384;
        r.op = OP_WR_UF; send_req(r, 0, '0);
        r.wval = $signed($urandom_range(0, 32768)) - 16384;
        r.op = OP_WR_IF; send_req(r, 0, '0);
      end
      r.wval = $signed($urandom_range(0, 8192)) - 4096;
      r.op = OP_WR_UB; send_req(r, 0, '0);
      r.op = OP_WR_IB; send_req(r, 0, '0);
    end
    wait_drained();

    // directed table: extremes, every op, unused codes
    rw.chk = 1;
    rw.req = '{OP_WR_UB, 10'd1, 10'd0, 5'd0, 32'sd0, 32'sh7fffffff};
    rw.rsp = '0; rows = {rows, rw};
    rw.req = '{OP_RD_UB, 10'd1, 10'd0, 5'd0, 32'sd0, 32'sd0};
    rw.rsp = '{0, 0, 32'sh7fffffff}; rows = {rows, rw};
    rw.req = '{OP_WR_IB, 10'd0, 10'h3ff, 5'd0, 32'sd0, 32'sh80000000};
    rw.rsp = '0; rows = {rows, rw};
    rw.req = '{OP_RD_IB, 10'd0, 10'h3ff, 5'd0, 32'sd0, 32'sd0};
    rw.rsp = '{0, 0, 32'sh80000000}; rows = {rows, rw};
    rw.req = '{OP_WR_UF, 10'h3ff, 10'd0, 5'd31, 32'sd0, 32'sh80000000};
    rw.rsp = '0; rows = {rows, rw};
    rw.req = '{OP_RD_UF, 10'h3ff, 10'd0, 5'd31, 32'sd0, 32'sd0};
    rw.rsp = '{0, 0, 32'sh80000000}; rows = {rows, rw};
    rw.req = '{OP_WR_IF, 10'd0, 10'd3, 5'd0, 32'sd0, 32'sh7fffffff};
    rw.rsp = '0; rows = {rows, rw};
    rw.req = '{OP_RD_IF, 10'd0, 10'd3, 5'd0, 32'sd0, 32'sd0};
    rw.rsp = '{0, 0, 32'sh7fffffff}; rows = {rows, rw};
    rw.req = '{4'd9, 10'h3ff, 10'h3ff, 5'h1f, 32'shffffffff, 32'shffffffff};
    rw.rsp = '0; rows = {rows, rw};
    rw.req = '{4'd15, 10'h155, 10'h2aa, 5'h15, 32'sh55555555, 32'shaaaaaaaa};
    rw.rsp = '0; rows = {rows, rw};
    rw.chk = 0;
    rw.req = '{OP_TRAIN, 10'd1, 10'd3, 5'd0, 32'sh7fffffff, 32'sd0};
    rows = {rows, rw};
    rw.req = '{OP_TRAIN, 10'h3fb, 10'h3fb, 5'd0, 32'sh80000000, 32'sd0};
    rows = {rows, rw};
    rw.req = '{OP_TRAIN, 10'd2, 10'd3, 5'd0, 32'sd65536, 32'sd0};
    rows = {rows, rw};
    rw.req = '{OP_RD_UF, 10'd2, 10'd3, 5'd9, 32'sd0, 32'sd0};
    rows = {rows, rw};
    foreach (rows[k]) send_req(rows[k].req, rows[k].chk, rows[k].rsp);
    wait_drained();

    // configuration phases, the first ones the extremes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: regs = '{32'hffff, 32'hffff, 32'hffff, 32'hffff, 32'hffff, 32'h7fffffff, 32'd1};
        1: regs = '{32'd0, 32'd0, 32'd0, 32'h1ffff, 32'h1ffff, 32'h80000000, 32'd3};
        2: regs = '{32'd655, 32'd655, 32'd655, 32'd0, 32'h1ffff, 32'h00030000, 32'd2};
        default: regs = '{$urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535),
                          $urandom_range(0, 3) == 0 ? 32'h1ffff : $urandom_range(0, 65535),
                          $urandom_range(0, 3) == 0 ? 32'h1ffff : $urandom_range(0, 65535),
                          $urandom_range(0, 1) ? $urandom : $urandom_range(0, 262144),
                          $urandom_range(0, 3)};
      endcase
      for (int k = 0; k < 7; k++) set_reg(cfg_e'(k), regs[k]);
      for (int it = 0; it < 80; ) begin
        burst = $urandom_range(1, 12);
        if (ph == 4 && !held && it >= 30) begin
          // long receiver hold while requests keep coming
          held = 1'b1;
          fork
            begin hold_rx = 1'b1; repeat (600) @(negedge clk_i); hold_rx = 1'b0; end
          join_none
        end
        if (ph == 5 && !paused && it >= 40) begin
          paused = 1'b1;
          wait_drained();
        end
        for (int b = 0; b < burst; b++) begin
          r = rand_req();
          if (r.op == OP_TRAIN) n_train++;
          if (r.op >= OP_RD_UF && r.op <= OP_RD_IB) n_read++;
          send_req(r, 0, '0);
          it++;
        end
        if (!(ph == 4 && hold_rx)) gap();
      end
      wait_drained();
    end

    wait_drained();
    $display("%0d requests, %0d train, %0d reads, %0d responses, 8 register settings",
             n_sent, n_train, n_read, n_got);
    if (n_err == 0 && pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
